@@ rtl/core/phw_pkg.sv @@
// ----------------------------------------------------------------------------
// Pipeline health watchdog package
// Shared widths, codes and the saturating timer add of the health watchdog.
// ----------------------------------------------------------------------------
package phw_pkg;

    localparam int TIMER_BITS = 16;
    localparam int DT_W       = 16;
    localparam int CFG_W      = 16;
    localparam int CNT_W      = 32;
    localparam int CYC_W      = 64;
    localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam int SUM_W      = ((TIMER_BITS > DT_W) ? TIMER_BITS : DT_W) + 1;
    localparam int CFG_IDX_W  = 2;

    localparam int S_TDATA_W  = 176;
    localparam int M_TDATA_W  = 8;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    localparam logic [CFG_W-1:0] STALL_LIMIT_RESET = CFG_W'(750);
    localparam logic [CFG_W-1:0] GRACE_RESET       = CFG_W'(2000);

    typedef enum logic [2:0] {
        HS_HEALTHY       = 3'd0,
        HS_CLOCK_DEAD    = 3'd1,
        HS_PIPELINE_HANG = 3'd2,
        HS_IRQ_LOST      = 3'd3,
        HS_CAPTURE_STALL = 3'd4
    } health_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STALL_LIMIT  = 2'd0,
        CFG_GRACE        = 2'd1,
        CFG_TRIGGER_MODE = 2'd2
    } cfg_index_t;

    function automatic logic [TIMER_BITS-1:0] timer_sat_add(
        input logic [TIMER_BITS-1:0] t,
        input logic [DT_W-1:0]       d
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(t) + SUM_W'(d);
        if (s > SUM_W'(TIMER_MAX)) begin
            return TIMER_MAX;
        end
        return s[TIMER_BITS-1:0];
    endfunction

endpackage

@@ rtl/core/pipeline_health_watchdog_top.sv @@
// ----------------------------------------------------------------------------
// Pipeline health watchdog
// Classifies poll samples of a streaming pipeline's counters into a health
// state, with saturating millisecond stall timers and a grace period.
// ----------------------------------------------------------------------------
// Latency: a result item is registered and is valid in the cycle after its sample item is accepted.
// Throughput: one sample item per cycle; the single output register is the
// only stage, and a new item is taken whenever that register is free or drained.
// Reset (aresetn low, synchronous) clears the timers, the seeded flag, the
// health state and the output valid, and loads the register defaults.
// ----------------------------------------------------------------------------
module pipeline_health_watchdog_top
    import phw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // frame_num[31:0], irq_count[63:32], capture_count[95:64],
    // cycle_count[159:96], elapsed_ms[175:160]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // irq_valid[0]
    input  logic                  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // health_state[2:0], state_changed[3], recover_request[4], zero[7:5]
    output logic [M_TDATA_W-1:0]  m_tdata,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    logic [CFG_W-1:0]       stall_limit_reg;
    logic [CFG_W-1:0]       grace_reg;
    logic                   trigger_mode_reg;

    logic                   seeded_reg;
    logic [CNT_W-1:0]       last_frame_reg;
    logic [CNT_W-1:0]       last_irq_reg;
    logic                   last_irq_valid_reg;
    logic [CNT_W-1:0]       last_capture_reg;
    logic [CYC_W-1:0]       last_cycles_reg;
    logic [TIMER_BITS-1:0]  since_start_reg;
    logic [TIMER_BITS-1:0]  since_frame_reg;
    logic [TIMER_BITS-1:0]  since_irq_reg;
    logic [TIMER_BITS-1:0]  since_capture_reg;
    health_t                cur_health_reg;

    logic                   m_valid_reg;
    health_t                out_health_reg;
    logic                   out_changed_reg;
    logic                   out_recover_reg;

    logic [CNT_W-1:0]       in_frame;
    logic [CNT_W-1:0]       in_irq;
    logic [CNT_W-1:0]       in_capture;
    logic [CYC_W-1:0]       in_cycles;
    logic [DT_W-1:0]        in_dt;
    logic                   in_irq_ok;

    logic                   accept;
    logic                   frame_chg;
    logic                   irq_chg;
    logic                   cap_chg;
    logic                   clk_frozen;
    logic                   capture_live;
    logic                   frame_stuck;
    logic                   irq_stuck;
    logic                   in_grace;

    logic [TIMER_BITS-1:0]  since_start_next;
    logic [TIMER_BITS-1:0]  since_frame_next;
    logic [TIMER_BITS-1:0]  since_irq_next;
    logic [TIMER_BITS-1:0]  since_capture_next;
    health_t                class_health;
    health_t                cur_health_next;
    logic                   changed_next;
    logic                   recover_next;

    assign in_frame   = s_tdata[31:0];
    assign in_irq     = s_tdata[63:32];
    assign in_capture = s_tdata[95:64];
    assign in_cycles  = s_tdata[159:96];
    assign in_dt      = s_tdata[175:160];
    assign in_irq_ok  = s_tuser;

    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, out_recover_reg, out_changed_reg, out_health_reg};

    assign frame_chg  = in_frame != last_frame_reg;
    assign irq_chg    = (in_irq_ok != last_irq_valid_reg)
                        || (in_irq_ok && (in_irq != last_irq_reg));
    assign cap_chg    = in_capture != last_capture_reg;
    assign clk_frozen = in_cycles == last_cycles_reg;

    assign since_start_next   = timer_sat_add(since_start_reg, in_dt);
    assign since_frame_next   = frame_chg ? '0 : timer_sat_add(since_frame_reg, in_dt);
    assign since_irq_next     = irq_chg ? '0 : timer_sat_add(since_irq_reg, in_dt);
    assign since_capture_next = cap_chg ? '0 : timer_sat_add(since_capture_reg, in_dt);

    assign capture_live = CMP_W'(since_capture_next) < CMP_W'(stall_limit_reg);
    assign frame_stuck  = CMP_W'(since_frame_next) > CMP_W'(stall_limit_reg);
    assign irq_stuck    = CMP_W'(since_irq_next) > CMP_W'(stall_limit_reg);
    assign in_grace     = CMP_W'(since_start_next) < CMP_W'(grace_reg);

    always_comb begin
        if (clk_frozen) begin
            class_health = HS_CLOCK_DEAD;
        end else if (trigger_mode_reg) begin
            class_health = HS_HEALTHY;
        end else if (capture_live && frame_stuck) begin
            class_health = HS_PIPELINE_HANG;
        end else if (!capture_live) begin
            class_health = HS_CAPTURE_STALL;
        end else if (irq_stuck && in_irq_ok) begin
            class_health = HS_IRQ_LOST;
        end else begin
            class_health = HS_HEALTHY;
        end
    end

    always_comb begin
        cur_health_next = cur_health_reg;
        changed_next    = 1'b0;
        recover_next    = 1'b0;
        if (seeded_reg && !in_grace && (class_health != cur_health_reg)) begin
            cur_health_next = class_health;
            changed_next    = 1'b1;
            recover_next    = class_health == HS_PIPELINE_HANG;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stall_limit_reg  <= STALL_LIMIT_RESET;
            grace_reg        <= GRACE_RESET;
            trigger_mode_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_STALL_LIMIT:  stall_limit_reg  <= cfg_wdata;
                CFG_GRACE:        grace_reg        <= cfg_wdata;
                CFG_TRIGGER_MODE: trigger_mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seeded_reg        <= 1'b0;
            since_start_reg   <= '0;
            since_frame_reg   <= '0;
            since_irq_reg     <= '0;
            since_capture_reg <= '0;
            cur_health_reg    <= HS_HEALTHY;
        end else if (accept) begin
            seeded_reg <= 1'b1;
            if (seeded_reg) begin
                since_start_reg   <= since_start_next;
                since_frame_reg   <= since_frame_next;
                since_irq_reg     <= since_irq_next;
                since_capture_reg <= since_capture_next;
                cur_health_reg    <= cur_health_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            last_frame_reg   <= in_frame;
            last_capture_reg <= in_capture;
            last_cycles_reg  <= in_cycles;
            if (!seeded_reg || irq_chg) begin
                last_irq_reg       <= in_irq;
                last_irq_valid_reg <= in_irq_ok;
            end
            out_health_reg  <= cur_health_next;
            out_changed_reg <= changed_next;
            out_recover_reg <= recover_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= s_tvalid;
        end
    end

    a_recover_is_hang_change: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_recover_reg |->
            out_changed_reg && (out_health_reg == HS_PIPELINE_HANG))
        else $error("recover request without a change into pipeline hang");

    a_output_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> out_health_reg == cur_health_reg)
        else $error("reported health differs from the held health state");

    a_timers_bounded_by_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (since_frame_reg <= since_start_reg) && (since_irq_reg <= since_start_reg)
            && (since_capture_reg <= since_start_reg))
        else $error("a change timer ran ahead of the start timer");

    a_unseeded_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !seeded_reg |-> (since_start_reg == '0) && (cur_health_reg == HS_HEALTHY))
        else $error("timers or health moved before the seeding item");

endmodule
